@@ rtl/irc_line_tokenizer_core_defines.svh @@
// Assertion macros used by the tokenizer checker.
`ifndef IRC_LINE_TOKENIZER_CORE_DEFINES_SVH
`define IRC_LINE_TOKENIZER_CORE_DEFINES_SVH

// A stalled request keeps its payload until it is taken.
`define IRC_TOK_ASSERT_HOLD(lbl, vld, rdy, sig) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    ((vld) && !(rdy)) |=> $stable(sig)) \
    else $error("payload changed while stalled");

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define IRC_TOK_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) \
    else $error("result field rule violated");

`endif

@@ rtl/irc_tok_pkg.sv @@
package irc_tok_pkg;

  // Characters that steer the tokenizer
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChBang  = 8'h21;
  localparam logic [7:0] ChAt    = 8'h40;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;

  // Component limit
  localparam int unsigned MaxParts = 15;
  localparam logic [3:0]  LimCap   = (MaxParts > 15) ? 4'd15 : 4'(MaxParts);
  localparam logic [3:0]  LimReset = 4'd15;

  // Result roles
  localparam logic [1:0] RoleDrop   = 2'd0;
  localparam logic [1:0] RolePrefix = 2'd1;
  localparam logic [1:0] RoleMiddle = 2'd2;
  localparam logic [1:0] RoleTrail  = 2'd3;

  // Prefix parts
  localparam logic [1:0] PartHead = 2'd0;
  localparam logic [1:0] PartUser = 2'd1;
  localparam logic [1:0] PartHost = 2'd2;

  // Queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = 2;

  // One byte to classify, with what the front knows of its successor
  typedef struct packed {
    logic [7:0] data;
    logic       has_la;
    logic       la_space;
    logic       la_colon;
    logic       is_final;
    logic       term;
  } req_t;

  // Up to two requests written by the front in one cycle
  typedef struct packed {
    logic wr0;
    logic wr1;
    req_t req0;
    req_t req1;
  } push_t;

  // One classified byte
  typedef struct packed {
    logic [7:0] byte_value;
    logic [1:0] role;
    logic [3:0] component_index;
    logic [1:0] prefix_part;
    logic       ends_component;
    logic       last_result;
    logic [3:0] component_count;
    logic       has_user;
  } res_t;

endpackage

@@ rtl/irc_tok_queue.sv @@
module irc_tok_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  irc_tok_pkg::push_t  push_i,
  output logic                room_two_o,
  output logic                rd_valid_o,
  output irc_tok_pkg::req_t   rd_req_o,
  input  logic                rd_pop_i
);
  import irc_tok_pkg::*;

  req_t             mem_q [QDepth];
  logic [QAw-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QAw-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QAw:0]     cnt_q, cnt_d;
  logic [QAw-1:0]   wr_ptr_nx;
  logic [QAw:0]     n_wr;

  assign wr_ptr_nx  = wr_ptr_q + QAw'(1);
  assign n_wr       = (QAw+1)'(push_i.wr0) + (QAw+1)'(push_i.wr1);
  assign room_two_o = cnt_q <= (QAw+1)'(QDepth - 2);
  assign rd_valid_o = cnt_q != '0;
  assign rd_req_o   = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q + n_wr[QAw-1:0];
    rd_ptr_d = rd_ptr_q + QAw'(rd_pop_i);
    cnt_d    = cnt_q + n_wr - (QAw+1)'(rd_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store requests; the second one lands after the first
  always_ff @(posedge clk_i) begin
    if (push_i.wr0) begin
      mem_q[wr_ptr_q] <= push_i.req0;
    end
    if (push_i.wr1) begin
      mem_q[wr_ptr_nx] <= push_i.req1;
    end
  end

endmodule

@@ rtl/irc_tok_front.sv @@
module irc_tok_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_fire_i,
  input  logic [7:0]          data_byte_i,
  input  logic                line_end_i,
  output irc_tok_pkg::push_t  push_o
);
  import irc_tok_pkg::*;

  logic       held_valid_q, held_valid_d;
  logic [7:0] held_byte_q, held_byte_d;
  req_t       held_req;
  req_t       final_req;

  // Held byte, classified now that its successor is known
  always_comb begin
    held_req.data     = held_byte_q;
    held_req.has_la   = 1'b1;
    held_req.la_space = data_byte_i == ChSpace;
    held_req.la_colon = data_byte_i == ChColon;
    held_req.is_final = 1'b0;
    held_req.term     = (held_byte_q == ChCr) && line_end_i && (data_byte_i == ChLf);
  end

  // Final byte of the line, no successor
  always_comb begin
    final_req.data     = data_byte_i;
    final_req.has_la   = 1'b0;
    final_req.la_space = 1'b0;
    final_req.la_colon = 1'b0;
    final_req.is_final = 1'b1;
    final_req.term     = 1'b0;
  end

  // Issue held byte first, then the final byte
  always_comb begin
    push_o.wr0  = in_fire_i && (held_valid_q || line_end_i);
    push_o.wr1  = in_fire_i && held_valid_q && line_end_i;
    push_o.req0 = held_valid_q ? held_req : final_req;
    push_o.req1 = final_req;
  end

  // Hold the byte for one item unless the line ends
  always_comb begin
    held_valid_d = held_valid_q;
    held_byte_d  = held_byte_q;
    if (in_fire_i) begin
      held_valid_d = !line_end_i;
      held_byte_d  = data_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
    end else begin
      held_valid_q <= held_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_byte_q <= held_byte_d;
  end

endmodule

@@ rtl/irc_tok_back.sv @@
module irc_tok_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [3:0]         part_limit_i,
  input  logic               rd_valid_i,
  input  irc_tok_pkg::req_t  rd_req_i,
  output logic               rd_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output irc_tok_pkg::res_t  out_res_o
);
  import irc_tok_pkg::*;

  localparam logic [2:0] PhStart  = 3'd0;
  localparam logic [2:0] PhPrefix = 3'd1;
  localparam logic [2:0] PhGap    = 3'd2;
  localparam logic [2:0] PhMid    = 3'd3;
  localparam logic [2:0] PhColon  = 3'd4;
  localparam logic [2:0] PhTrail  = 3'd5;
  localparam logic [2:0] PhDone   = 3'd6;

  logic [2:0] phase_q, phase_d;
  logic [3:0] cnt_q, cnt_d;
  logic [1:0] mark_q, mark_d;
  logic       saw_q, saw_d;
  logic       out_valid_q, out_valid_d;
  res_t       res_q, res_d;
  logic [3:0] lim;

  function automatic logic is_open(input logic [2:0] ph);
    is_open = (ph == PhPrefix) || (ph == PhMid) || (ph == PhColon) || (ph == PhTrail);
  endfunction

  // Effective limit: zero acts as one, capped by the design maximum
  always_comb begin
    lim = (part_limit_i == 4'd0) ? 4'd1 : part_limit_i;
    if (lim > LimCap) begin
      lim = LimCap;
    end
  end

  // Take a request whenever the output register is free or drains
  assign rd_pop_o = rd_valid_i && (!out_valid_q || out_ready_i);

  // Classify one byte
  always_comb begin
    logic [2:0] ph;
    logic [3:0] cnt;
    logic [1:0] mark;
    logic       sat;
    logic [1:0] role;
    logic [3:0] idx;
    logic [1:0] part;
    logic       ends;
    logic [7:0] b;

    ph   = phase_q;
    cnt  = cnt_q;
    mark = mark_q;
    sat  = saw_q;
    role = RoleDrop;
    idx  = 4'd0;
    part = PartHead;
    ends = 1'b0;
    b    = rd_req_i.data;

    if (rd_req_i.term) begin
      // CR before the final LF: close what is open and drop it
      if (is_open(ph)) begin
        ends = 1'b1;
        idx  = cnt;
        cnt  = cnt + 4'd1;
      end
      ph = PhDone;
    end else if (ph == PhPrefix) begin
      if (b == ChSpace) begin
        ends = 1'b1;
        idx  = cnt;
        cnt  = cnt + 4'd1;
        ph   = (cnt >= lim) ? PhDone : PhGap;
      end else begin
        role = RolePrefix;
        idx  = cnt;
        part = mark;
        if (b == ChBang) begin
          if (mark == PartHead) begin
            mark = PartUser;
          end
        end else if (b == ChAt) begin
          mark = PartHost;
          sat  = 1'b1;
        end
      end
    end else if ((ph == PhStart) && (b == ChColon)) begin
      ph = PhPrefix;
    end else if ((ph == PhStart) || (ph == PhGap) || (ph == PhMid)) begin
      if ((b == ChSpace) && !(rd_req_i.has_la && rd_req_i.la_space)) begin
        ends = 1'b1;
        idx  = cnt;
        cnt  = cnt + 4'd1;
        ph   = (cnt >= lim) ? PhDone : PhGap;
        if ((ph != PhDone) && rd_req_i.has_la && rd_req_i.la_colon) begin
          ph = PhColon;
        end
      end else begin
        role = RoleMiddle;
        idx  = cnt;
        ph   = PhMid;
      end
    end else if (ph == PhColon) begin
      ph = PhTrail;
    end else if (ph == PhTrail) begin
      role = RoleTrail;
      idx  = cnt;
    end

    // Close whatever is still open at end of line
    if (rd_req_i.is_final && is_open(ph)) begin
      ends = 1'b1;
      idx  = cnt;
      cnt  = cnt + 4'd1;
      ph   = (cnt >= lim) ? PhDone : PhGap;
    end

    res_d.byte_value      = b;
    res_d.role            = role;
    res_d.component_index = idx;
    res_d.prefix_part     = part;
    res_d.ends_component  = ends;
    res_d.last_result     = rd_req_i.is_final;
    res_d.component_count = cnt;
    res_d.has_user        = sat;

    // Line state returns to start after the final byte
    if (rd_req_i.is_final) begin
      phase_d = PhStart;
      cnt_d   = 4'd0;
      mark_d  = PartHead;
      saw_d   = 1'b0;
    end else begin
      phase_d = ph;
      cnt_d   = cnt;
      mark_d  = mark;
      saw_d   = sat;
    end
  end

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (rd_pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhStart;
      cnt_q       <= 4'd0;
      mark_q      <= PartHead;
      saw_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (rd_pop_o) begin
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
        mark_q  <= mark_d;
        saw_q   <= saw_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_pop_o) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

endmodule

@@ rtl/irc_line_tokenizer_core.sv @@
// IRC line tokenizer.
// Input stream: one byte of a message line per request in s_axis_tdata_i,
// s_axis_tlast_i marks the final byte of the line.
// Output stream: one result per input byte, in order; the byte value, its
// role, component index, prefix part and running counts are packed in
// m_axis_tdata_o, and m_axis_tlast_o marks the final result of the line.
// A byte is reported only once the next byte is known: it is written to
// the queue when the byte that follows it is accepted, and its result then
// passes through the output register; a final byte releases the held byte
// and itself, two results from one request.
// Throughput: one byte per cycle sustained unless the output stalls,
// set by the single classify stage in the back end that emits one result
// per cycle; a four-entry queue sits between the byte front end and the
// classifier. Config: register part_limit at byte address 0 over the APB
// port. Reset clears the held byte, the queue and the line state; the limit
// returns to 15. When the receiver stalls, the output register holds,
// the queue fills, and s_axis_tready_o drops once fewer than two entries
// remain free.
module irc_line_tokenizer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,
  // Output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] byte_value, [9:8] role, [13:10] component_index,
  // [15:14] prefix_part, [16] ends_component, [20:17] component_count,
  // [21] has_user, [23:22] zero
  output logic [23:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import irc_tok_pkg::*;

  logic       limit_wr;
  logic [3:0] part_limit_q;
  logic       in_fire;
  logic       room_two;
  push_t      push;
  logic       rd_valid;
  req_t       rd_req;
  logic       rd_pop;
  res_t       res;

  // Register file
  assign pready   = 1'b1;
  assign limit_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata   = (paddr[2] == 1'b0) ? {28'd0, part_limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_limit_q <= LimReset;
    end else if (limit_wr) begin
      part_limit_q <= pwdata[3:0];
    end
  end

  // Accept a byte when the queue can take two requests
  assign s_axis_tready_o = room_two;
  assign in_fire         = s_axis_tvalid_i && room_two;

  irc_tok_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .data_byte_i (s_axis_tdata_i),
    .line_end_i  (s_axis_tlast_i),
    .push_o      (push)
  );

  irc_tok_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .room_two_o (room_two),
    .rd_valid_o (rd_valid),
    .rd_req_o   (rd_req),
    .rd_pop_i   (rd_pop)
  );

  irc_tok_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .part_limit_i (part_limit_q),
    .rd_valid_i   (rd_valid),
    .rd_req_i     (rd_req),
    .rd_pop_o     (rd_pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_res_o    (res)
  );

  // Pack the result
  assign m_axis_tdata_o = {2'b00, res.has_user, res.component_count,
                           res.ends_component, res.prefix_part,
                           res.component_index, res.role, res.byte_value};
  assign m_axis_tlast_o = res.last_result;

endmodule

@@ rtl/irc_tok_checker.sv @@
`include "irc_line_tokenizer_core_defines.svh"

module irc_tok_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  input  logic [23:0] m_axis_tdata_o,
  input  logic        m_axis_tlast_o
);
  import irc_tok_pkg::*;

  logic [24:0] out_word;
  logic [1:0]  role;
  logic [3:0]  idx;
  logic [1:0]  part;
  logic        ends;
  logic [1:0]  pad;

  // Split the result word into its fields
  assign out_word = {m_axis_tlast_o, m_axis_tdata_o};
  assign role     = m_axis_tdata_o[9:8];
  assign idx      = m_axis_tdata_o[13:10];
  assign part     = m_axis_tdata_o[15:14];
  assign ends     = m_axis_tdata_o[16];
  assign pad      = m_axis_tdata_o[23:22];

  `IRC_TOK_ASSERT_HOLD(a_out_hold, m_axis_tvalid_o, m_axis_tready_i, out_word)

  `IRC_TOK_ASSERT_IMPL(a_drop_index, m_axis_tvalid_o && (role == RoleDrop) && !ends, idx == 4'd0)

  `IRC_TOK_ASSERT_IMPL(a_part_prefix_only, m_axis_tvalid_o && (role != RolePrefix), part == PartHead)

  `IRC_TOK_ASSERT_IMPL(a_index_range, m_axis_tvalid_o, (idx != 4'd15) && (pad == 2'd0))

endmodule

bind irc_line_tokenizer_core irc_tok_checker u_irc_tok_checker (.*);
